// ----- src/lpfd_pkg.sv -----
// Shared types and constants for the length-prefixed frame deframer.
package lpfd_pkg;

  localparam logic [2:0] HdrLen   = 3'd6;
  localparam logic [2:0] HdrLenB0 = 3'd0;
  localparam logic [2:0] HdrLenB1 = 3'd1;
  localparam logic [2:0] HdrLenB2 = 3'd2;
  localparam logic [2:0] HdrLenB3 = 3'd3;
  localparam logic [2:0] HdrIdLo  = 3'd4;
  localparam logic [2:0] HdrIdHi  = 3'd5;

  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic [15:0] message_id;
    logic [7:0]  body_byte;
    logic        has_data;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t data;
  } push_t;

endpackage

// ----- src/length_prefixed_frame_deframer_unit.sv -----
// Top level of the length-prefixed frame deframer.
//
// Input channel: one stream byte per transfer (in_valid_i / in_stall_o).
// Each frame is a 6-byte header (32-bit little-endian body length, then a
// 16-bit little-endian message id) followed by that many body bytes.
// Output channel (out_valid_o / out_stall_i): one transfer per body byte,
// tagged with the message id, last_of_frame set on the final byte. A frame
// with zero length yields one transfer with has_data low and last_of_frame
// high when its header completes. Header bytes otherwise yield nothing.
// Throughput: one byte per cycle while in_stall_o is low; the parser updates
// its counters once per accepted byte. Each result is written into the queue
// as the byte that caused it is accepted, and leaves after earlier entries.
// A two-entry queue sits between the parser and the output; in_stall_o is
// high only while that queue is full, so a stalled receiver backs up the
// input after two pending results.
// Reset clears the parser to expect a header byte and empties the queue.
module length_prefixed_frame_deframer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] message_id_o,
  output logic [7:0]  body_byte_o,
  output logic        has_data_o,
  output logic        last_of_frame_o
);
  import lpfd_pkg::*;

  push_t   push;
  result_t out_data;
  logic    full;
  logic    accept;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  lpfd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .stream_byte_i (stream_byte_i),
    .push_o        (push)
  );

  lpfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign message_id_o    = out_data.message_id;
  assign body_byte_o     = out_data.body_byte;
  assign has_data_o      = out_data.has_data;
  assign last_of_frame_o = out_data.last_of_frame;

endmodule

// ----- src/lpfd_front.sv -----
// Front end: header parsing, body counting and result generation.
module lpfd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     stream_byte_i,
  output lpfd_pkg::push_t push_o
);
  import lpfd_pkg::*;

  logic [2:0]  hc_q, hc_d, hc_eff;
  logic [31:0] len_q, len_d;
  logic [15:0] id_q, id_d;
  logic [31:0] rem_q, rem_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= '0;
      len_q <= '0;
      id_q  <= '0;
      rem_q <= '0;
    end else begin
      hc_q  <= hc_d;
      len_q <= len_d;
      id_q  <= id_d;
      rem_q <= rem_d;
    end
  end

  always_comb begin
    hc_d   = hc_q;
    len_d  = len_q;
    id_d   = id_q;
    rem_d  = rem_q;
    hc_eff = (hc_q >= HdrLen) ? '0 : hc_q;
    push_o = '0;
    if (accept_i) begin
      if (hc_q == HdrLen && rem_q != '0) begin
        rem_d                       = rem_q - 32'd1;
        push_o.push                 = 1'b1;
        push_o.data.message_id      = id_q;
        push_o.data.body_byte       = stream_byte_i;
        push_o.data.has_data        = 1'b1;
        push_o.data.last_of_frame   = (rem_q == 32'd1);
        if (rem_q == 32'd1) begin
          hc_d = '0;
        end
      end else begin
        hc_d = hc_eff + 3'd1;
        unique case (hc_eff)
          HdrLenB0: len_d = {24'b0, stream_byte_i};
          HdrLenB1: len_d = len_q | {16'b0, stream_byte_i, 8'b0};
          HdrLenB2: len_d = len_q | {8'b0, stream_byte_i, 16'b0};
          HdrLenB3: len_d = len_q | {stream_byte_i, 24'b0};
          HdrIdLo:  id_d  = {8'b0, stream_byte_i};
          HdrIdHi: begin
            id_d = {stream_byte_i, id_q[7:0]};
            if (len_q == '0) begin
              hc_d                      = '0;
              rem_d                     = '0;
              push_o.push               = 1'b1;
              push_o.data.message_id    = {stream_byte_i, id_q[7:0]};
              push_o.data.body_byte     = '0;
              push_o.data.has_data      = 1'b0;
              push_o.data.last_of_frame = 1'b1;
            end else begin
              hc_d  = HdrLen;
              rem_d = len_q;
            end
          end
          default: hc_d = '0;
        endcase
      end
    end
  end

endmodule

// ----- src/lpfd_queue.sv -----
// Two-entry result queue between the parser and the output channel.
module lpfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpfd_pkg::push_t   push_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lpfd_pkg::result_t out_data_o
);
  import lpfd_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              pop;

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign full_o      = (cnt_q == QCntW'(QDepth));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i.push && !pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop && !push_i.push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i.push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule
